// File: hdl/pin_change_event_queue_unit_assert.svh
// ------------------------------------------------------------------------
// pin change event queue assertion macros
// shared property forms for the concurrent checks of the block
// ------------------------------------------------------------------------
`ifndef PIN_CHANGE_EVENT_QUEUE_UNIT_ASSERT_SVH
`define PIN_CHANGE_EVENT_QUEUE_UNIT_ASSERT_SVH

// condition in one cycle implies a consequence in the same cycle
`define PCEQ_ASSERT_SAME(name, clk, rst_n, pre, post, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error(msg);

// condition in one cycle implies a consequence in the next cycle
`define PCEQ_ASSERT_NEXT(name, clk, rst_n, pre, post, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error(msg);

`endif

// File: hdl/pceq_pkg.sv
// ------------------------------------------------------------------------
// pceq_pkg
// types, codes and constants shared by the pin change event queue
// ------------------------------------------------------------------------
package pceq_pkg;

    // field widths
    localparam int OPCODE_W    = 2;
    localparam int PORT_W      = 8;
    localparam int EVENT_W     = 8;
    localparam int CFG_INDEX_W = 2;
    localparam int SCAN_W      = 5;

    // default store depth
    localparam int QUEUE_DEPTH_DEFAULT = 32;

    // item opcodes
    localparam logic [OPCODE_W-1:0] OP_TICK     = 2'd0;
    localparam logic [OPCODE_W-1:0] OP_READ     = 2'd1;
    localparam logic [OPCODE_W-1:0] OP_BASELINE = 2'd2;

    // register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_MASK_B = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_MASK_C = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_MASK_D = 2'd2;

    // event byte fields
    localparam logic [EVENT_W-1:0] PORT_CODE_B = 8'b0000_1000;
    localparam logic [EVENT_W-1:0] PORT_CODE_C = 8'b0001_0000;
    localparam logic [EVENT_W-1:0] PORT_CODE_D = 8'b0001_1000;
    localparam logic [EVENT_W-1:0] LEVEL_BIT   = 8'b1000_0000;

    // last position of the 24-bit change scan
    localparam logic [SCAN_W-1:0] SCAN_LAST = 5'd23;

    // sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_READ
    } state_t;

    // port code from the upper scan position bits
    function automatic logic [EVENT_W-1:0] port_code(input logic [1:0] sel);
        logic [EVENT_W-1:0] code;
        case (sel)
            2'd0:    code = PORT_CODE_B;
            2'd1:    code = PORT_CODE_C;
            2'd2:    code = PORT_CODE_D;
            default: code = '0;
        endcase
        return code;
    endfunction

endpackage

// File: hdl/pceq_if.sv
// ------------------------------------------------------------------------
// pceq channel interfaces
// valid/ready channels for items, results and register writes
// ------------------------------------------------------------------------

// input item channel
interface pceq_item_if
    import pceq_pkg::*;
();
    logic                valid;
    logic                ready;
    logic [OPCODE_W-1:0] opcode;
    logic [PORT_W-1:0]   pins_b;
    logic [PORT_W-1:0]   pins_c;
    logic [PORT_W-1:0]   pins_d;

    modport source (output valid, opcode, pins_b, pins_c, pins_d, input ready);
    modport sink   (input valid, opcode, pins_b, pins_c, pins_d, output ready);
endinterface

// result channel
interface pceq_result_if
    import pceq_pkg::*;
();
    logic               valid;
    logic               ready;
    logic [EVENT_W-1:0] event_code;
    logic               empty_res;

    modport source (output valid, event_code, empty_res, input ready);
    modport sink   (input valid, event_code, empty_res, output ready);
endinterface

// register write channel
interface pceq_cfg_if
    import pceq_pkg::*;
();
    logic                   valid;
    logic                   ready;
    logic [CFG_INDEX_W-1:0] index;
    logic [PORT_W-1:0]      data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// File: hdl/pin_change_event_queue_unit.sv
// sample tick: the item is taken in idle, then a scan of the 24 port bits, one port bit
//   per cycle through the event store write port; no new item is taken until the scan ends
// read: entry registered at the transfer, result registered once the result register is
//   free, so the next item is held off while an earlier result waits; a baseline stays idle
// reset: masks and stored samples all ones, positions zero, store contents
//   undefined until written (no clearing pass)
// ------------------------------------------------------------------------
// pin_change_event_queue_unit
// key port change detector with a ring store of event bytes
// ------------------------------------------------------------------------
`include "pin_change_event_queue_unit_assert.svh"

module pin_change_event_queue_unit
    import pceq_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
) (
    input  logic   clk,
    input  logic   rst_n,
    pceq_item_if.sink     item,
    pceq_result_if.source result,
    pceq_cfg_if.sink      cfg
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
    localparam int SCAN_BITS = 3 * PORT_W;

    // state
    state_t state_reg, state_next;

    logic [PORT_W-1:0] mask_b_reg, mask_c_reg, mask_d_reg;
    logic [PORT_W-1:0] prev_b_reg, prev_c_reg, prev_d_reg;
    logic [PORT_W-1:0] prev_b_next, prev_c_next, prev_d_next;

    logic [PTR_W-1:0] write_pos_reg, write_pos_next;
    logic [PTR_W-1:0] read_pos_reg, read_pos_next;

    logic [SCAN_BITS-1:0] diff_reg, diff_next;
    logic [SCAN_BITS-1:0] lvl_reg, lvl_next;
    logic [SCAN_W-1:0]    cnt_reg, cnt_next;

    logic empty_reg, empty_next;
    logic out_valid_reg, out_valid_next;
    logic [EVENT_W-1:0] out_code_reg;
    logic               out_empty_reg;

    // event store
    logic [EVENT_W-1:0] mem [QUEUE_DEPTH];
    logic [EVENT_W-1:0] rd_data_reg;

    // control
    logic item_xfer;
    logic mem_we;
    logic mem_re;
    logic load_res;
    logic out_free;

    logic [PORT_W-1:0]  new_b, new_c, new_d;
    logic [EVENT_W-1:0] wr_code;

    // masked fresh samples
    assign new_b = item.pins_b & mask_b_reg;
    assign new_c = item.pins_c & mask_c_reg;
    assign new_d = item.pins_d & mask_d_reg;

    assign item_xfer = item.valid && item.ready;
    assign out_free  = !out_valid_reg || result.ready;

    // event byte for the current scan position
    assign wr_code = port_code(cnt_reg[4:3]) | {5'b0, cnt_reg[2:0]}
                   | (lvl_reg[0] ? LEVEL_BIT : '0);

    // outputs of the sequencer
    always_comb
    begin
        item.ready = 1'b0;
        mem_we     = 1'b0;
        mem_re     = 1'b0;
        load_res   = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                item.ready = 1'b1;
                mem_re     = item.valid && (item.opcode == OP_READ);
            end
            ST_SCAN:
            begin
                mem_we = diff_reg[0];
            end
            ST_READ:
            begin
                load_res = out_free;
            end
            default:
            begin
                item.ready = 1'b0;
            end
        endcase
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (item_xfer && item.opcode == OP_TICK)
                    state_next = ST_SCAN;
                else if (item_xfer && item.opcode == OP_READ)
                    state_next = ST_READ;
            end
            ST_SCAN:
            begin
                if (cnt_reg == SCAN_LAST)
                    state_next = ST_IDLE;
            end
            ST_READ:
            begin
                if (out_free)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // datapath next values
    always_comb
    begin
        prev_b_next    = prev_b_reg;
        prev_c_next    = prev_c_reg;
        prev_d_next    = prev_d_reg;
        write_pos_next = write_pos_reg;
        read_pos_next  = read_pos_reg;
        diff_next      = diff_reg;
        lvl_next       = lvl_reg;
        cnt_next       = cnt_reg;
        empty_next     = empty_reg;
        out_valid_next = out_valid_reg;

        // tick and baseline take the masked samples
        if (item_xfer && (item.opcode == OP_TICK || item.opcode == OP_BASELINE))
        begin
            prev_b_next = new_b;
            prev_c_next = new_c;
            prev_d_next = new_d;
        end
        if (item_xfer && item.opcode == OP_TICK)
        begin
            diff_next = {new_d ^ prev_d_reg, new_c ^ prev_c_reg, new_b ^ prev_b_reg};
            lvl_next  = {new_d, new_c, new_b};
            cnt_next  = '0;
        end
        if (item_xfer && item.opcode == OP_READ)
            empty_next = (read_pos_reg == write_pos_reg);

        // one port bit per scan cycle
        if (state_reg == ST_SCAN)
        begin
            diff_next = diff_reg >> 1;
            lvl_next  = lvl_reg >> 1;
            cnt_next  = cnt_reg + SCAN_W'(1);
        end
        if (mem_we)
            write_pos_next = (write_pos_reg == PTR_LAST) ? '0 : write_pos_reg + PTR_W'(1);

        // result register
        if (result.valid && result.ready)
            out_valid_next = 1'b0;
        if (load_res)
        begin
            out_valid_next = 1'b1;
            if (!empty_reg)
                read_pos_next = (read_pos_reg == PTR_LAST) ? '0 : read_pos_reg + PTR_W'(1);
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            mask_b_reg    <= '1;
            mask_c_reg    <= '1;
            mask_d_reg    <= '1;
            prev_b_reg    <= '1;
            prev_c_reg    <= '1;
            prev_d_reg    <= '1;
            write_pos_reg <= '0;
            read_pos_reg  <= '0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            prev_b_reg    <= prev_b_next;
            prev_c_reg    <= prev_c_next;
            prev_d_reg    <= prev_d_next;
            write_pos_reg <= write_pos_next;
            read_pos_reg  <= read_pos_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
            // register write transfer
            if (cfg.valid && cfg.ready)
            begin
                if (cfg.index == REG_MASK_B)
                    mask_b_reg <= cfg.data;
                if (cfg.index == REG_MASK_C)
                    mask_c_reg <= cfg.data;
                if (cfg.index == REG_MASK_D)
                    mask_d_reg <= cfg.data;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        diff_reg  <= diff_next;
        lvl_reg   <= lvl_next;
        empty_reg <= empty_next;
        if (load_res)
        begin
            out_code_reg  <= empty_reg ? '0 : rd_data_reg;
            out_empty_reg <= empty_reg;
        end
    end

    // event store, one write and one registered read port
    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[write_pos_reg] <= wr_code;
        if (mem_re)
            rd_data_reg <= mem[read_pos_reg];
    end

    assign cfg.ready         = 1'b1;
    assign result.valid      = out_valid_reg;
    assign result.event_code = out_code_reg;
    assign result.empty_res  = out_empty_reg;

    // checks
    `PCEQ_ASSERT_NEXT(a_tick_starts_scan, clk, rst_n, item_xfer && item.opcode == OP_TICK, state_reg == ST_SCAN && cnt_reg == '0, "tick transfer did not start the scan")
    `PCEQ_ASSERT_NEXT(a_read_goes_read, clk, rst_n, item_xfer && item.opcode == OP_READ, state_reg == ST_READ, "read transfer did not reach the read state")
    `PCEQ_ASSERT_SAME(a_write_only_in_scan, clk, rst_n, mem_we, state_reg == ST_SCAN && !item.ready, "store written outside the scan")
    `PCEQ_ASSERT_NEXT(a_scan_ends, clk, rst_n, state_reg == ST_SCAN && cnt_reg == SCAN_LAST, state_reg == ST_IDLE, "scan ran past the last port bit")

endmodule

// File: tb/sv/testbench.sv
// ------------------------------------------------------------------------
// testbench for pin_change_event_queue_unit
// drives key samples, baselines and event reads through bursty transfers,
// keeps a running model of the masked samples and the event ring, and
// checks every read result in order; masks are changed between phases
// ------------------------------------------------------------------------
module testbench
    import pceq_pkg::*;
();

    localparam int DEPTH          = QUEUE_DEPTH_DEFAULT;
    localparam int PHASES         = 8;
    localparam int PHASE_ITEMS    = 116;
    localparam int PRESSURE_PHASE = 3;
    localparam int HOLD_CYCLES    = 400;
    // a tick keeps the block busy after its transfer until its scan ends
    localparam int SETTLE_CYCLES  = 40;
    localparam int RUN_LIMIT      = 4_000_000;

    // opcode the block ignores
    localparam logic [OPCODE_W-1:0] OP_UNUSED = 2'd3;

    typedef struct packed {
        logic [OPCODE_W-1:0] opcode;
        logic [PORT_W-1:0]   pins_b;
        logic [PORT_W-1:0]   pins_c;
        logic [PORT_W-1:0]   pins_d;
    } key_item_t;

    typedef struct packed {
        logic [EVENT_W-1:0] event_code;
        logic               empty_res;
    } key_read_t;

    // receiver stall patterns
    typedef enum logic [1:0] {
        RX_OPEN,
        RX_COIN,
        RX_SPARSE,
        RX_CYCLIC
    } rx_mode_t;

    logic clk;
    logic rst_n;

    pceq_item_if   item_ch ();
    pceq_result_if result_ch ();
    pceq_cfg_if    cfg_ch ();

    pin_change_event_queue_unit #(
        .QUEUE_DEPTH(DEPTH)
    ) dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item_ch),
        .result (result_ch),
        .cfg    (cfg_ch)
    );

    // stimulus and expectation stores
    key_item_t pending_items[$];
    key_read_t awaited_reads[$];
    int        items_queued = 0;
    int        items_taken  = 0;
    int        error_count  = 0;
    int        phase_no     = -1;

    // running model of the block
    logic [PORT_W-1:0]  key_mask[3] = '{8'hFF, 8'hFF, 8'hFF};
    logic [PORT_W-1:0]  last_b = 8'hFF;
    logic [PORT_W-1:0]  last_c = 8'hFF;
    logic [PORT_W-1:0]  last_d = 8'hFF;
    logic [EVENT_W-1:0] ring[DEPTH];
    int                 ring_wr = 0;
    int                 ring_rd = 0;

    // raw pin levels the generator is holding
    logic [PORT_W-1:0]  raw_pins[3] = '{8'hFF, 8'hFF, 8'hFF};

    // one event byte per changed bit, lowest bit first
    function automatic void log_port_changes(input logic [PORT_W-1:0] fresh,
                                             input logic [PORT_W-1:0] old,
                                             input logic [EVENT_W-1:0] base);
        logic [EVENT_W-1:0] code;
        for (int i = 0; i < PORT_W; i++)
        begin
            if (fresh[i] != old[i])
            begin
                code = base | EVENT_W'(i);
                if (fresh[i])
                    code = code | LEVEL_BIT;
                ring[ring_wr] = code;
                ring_wr = (ring_wr + 1) % DEPTH;
            end
        end
    endfunction

    // update the model for one transferred item
    function automatic void predict_key_item(input key_item_t it);
        logic [PORT_W-1:0] nb;
        logic [PORT_W-1:0] nc;
        logic [PORT_W-1:0] nd;
        key_read_t         rd;
        nb = it.pins_b & key_mask[REG_MASK_B];
        nc = it.pins_c & key_mask[REG_MASK_C];
        nd = it.pins_d & key_mask[REG_MASK_D];
        case (it.opcode)
            OP_TICK:
            begin
                log_port_changes(nb, last_b, PORT_CODE_B);
                log_port_changes(nc, last_c, PORT_CODE_C);
                log_port_changes(nd, last_d, PORT_CODE_D);
                last_b = nb;
                last_c = nc;
                last_d = nd;
            end
            OP_READ:
            begin
                if (ring_rd != ring_wr)
                begin
                    rd.event_code = ring[ring_rd];
                    rd.empty_res  = 1'b0;
                    ring_rd = (ring_rd + 1) % DEPTH;
                end
                else
                begin
                    rd.event_code = '0;
                    rd.empty_res  = 1'b1;
                end
                awaited_reads.push_back(rd);
            end
            OP_BASELINE:
            begin
                last_b = nb;
                last_c = nc;
                last_d = nd;
            end
            default:
            begin
            end
        endcase
    endfunction

    // clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // run limit
    initial
    begin
        #RUN_LIMIT;
        $display("testbench: done, errors");
        $finish;
    end

    // item driver: bursts of random length with random gaps between them
    int gap_left;
    int burst_left;

    always @(posedge clk or negedge rst_n)
    begin
        key_item_t taken;
        key_item_t nxt;
        if (!rst_n)
        begin
            item_ch.valid  <= 1'b0;
            item_ch.opcode <= OP_TICK;
            item_ch.pins_b <= '0;
            item_ch.pins_c <= '0;
            item_ch.pins_d <= '0;
            gap_left       <= 0;
            burst_left     <= 0;
        end
        else
        begin
            // transfer at this edge
            if (item_ch.valid && item_ch.ready)
            begin
                taken.opcode = item_ch.opcode;
                taken.pins_b = item_ch.pins_b;
                taken.pins_c = item_ch.pins_c;
                taken.pins_d = item_ch.pins_d;
                predict_key_item(taken);
                items_taken = items_taken + 1;
            end
            // slot free for the next item
            if (!item_ch.valid || item_ch.ready)
            begin
                if (gap_left != 0)
                begin
                    gap_left      <= gap_left - 1;
                    item_ch.valid <= 1'b0;
                end
                else if (pending_items.size() != 0)
                begin
                    nxt = pending_items.pop_front();
                    item_ch.valid  <= 1'b1;
                    item_ch.opcode <= nxt.opcode;
                    item_ch.pins_b <= nxt.pins_b;
                    item_ch.pins_c <= nxt.pins_c;
                    item_ch.pins_d <= nxt.pins_d;
                    if (burst_left <= 1)
                    begin
                        burst_left <= $urandom_range(1, 24);
                        gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 15);
                    end
                    else
                        burst_left <= burst_left - 1;
                end
                else
                    item_ch.valid <= 1'b0;
            end
        end
    end

    // long receiver hold-off in the pressure phase
    int   hold_cnt;
    logic hold_busy;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_cnt  <= 0;
            hold_busy <= 1'b0;
        end
        else if (phase_no == PRESSURE_PHASE && hold_cnt < HOLD_CYCLES)
        begin
            hold_cnt  <= hold_cnt + 1;
            hold_busy <= (hold_cnt < HOLD_CYCLES - 1);
        end
        else
            hold_busy <= 1'b0;
    end

    // result receiver: stall pattern changes every so often
    rx_mode_t rx_mode;
    int       rx_left;
    int       rx_tick;

    always @(posedge clk or negedge rst_n)
    begin
        rx_mode_t m;
        int       left;
        logic     rdy;
        if (!rst_n)
        begin
            result_ch.ready <= 1'b0;
            rx_mode         <= RX_OPEN;
            rx_left         <= 0;
            rx_tick         <= 0;
        end
        else
        begin
            m    = rx_mode;
            left = rx_left;
            if (left == 0)
            begin
                m    = rx_mode_t'($urandom_range(0, 3));
                left = $urandom_range(20, 200);
            end
            else
                left = left - 1;
            case (m)
                RX_OPEN:   rdy = 1'b1;
                RX_COIN:   rdy = 1'($urandom_range(0, 1));
                RX_SPARSE: rdy = ($urandom_range(0, 3) == 0);
                default:   rdy = ((rx_tick % 5) < 3);
            endcase
            if (hold_busy)
                rdy = 1'b0;
            result_ch.ready <= rdy;
            rx_mode         <= m;
            rx_left         <= left;
            rx_tick         <= rx_tick + 1;
        end
    end

    // result monitor
    always @(posedge clk)
    begin
        key_read_t want;
        if (rst_n && result_ch.valid && result_ch.ready)
        begin
            if (awaited_reads.size() == 0)
            begin
                $display("%0t: unexpected result, expected none, actual event_code %h empty_res %b",
                         $time, result_ch.event_code, result_ch.empty_res);
                error_count = error_count + 1;
            end
            else
            begin
                want = awaited_reads.pop_front();
                if (result_ch.event_code !== want.event_code)
                begin
                    $display("%0t: event_code mismatch, expected %h, actual %h",
                             $time, want.event_code, result_ch.event_code);
                    error_count = error_count + 1;
                end
                if (result_ch.empty_res !== want.empty_res)
                begin
                    $display("%0t: empty_res mismatch, expected %b, actual %b",
                             $time, want.empty_res, result_ch.empty_res);
                    error_count = error_count + 1;
                end
            end
        end
    end

    task automatic queue_item(input logic [OPCODE_W-1:0] op,
                              input logic [PORT_W-1:0] b,
                              input logic [PORT_W-1:0] c,
                              input logic [PORT_W-1:0] d);
        key_item_t it;
        it.opcode = op;
        it.pins_b = b;
        it.pins_c = c;
        it.pins_d = d;
        pending_items.push_back(it);
        items_queued = items_queued + 1;
    endtask

    task automatic queue_raw(input logic [OPCODE_W-1:0] op);
        queue_item(op, raw_pins[0], raw_pins[1], raw_pins[2]);
    endtask

    // wait until every item is taken and every read answered, then let a tick finish
    task automatic wait_for_idle();
        do
            @(posedge clk);
        while (items_taken != items_queued || awaited_reads.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // one register write transfer
    task automatic set_key_mask(input logic [CFG_INDEX_W-1:0] idx,
                                input logic [PORT_W-1:0] val);
        @(posedge clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= val;
        do
            @(posedge clk);
        while (!cfg_ch.ready);
        key_mask[idx] = val;
        cfg_ch.valid <= 1'b0;
    endtask

    task automatic program_masks(input int p);
        logic [PORT_W-1:0] mb;
        logic [PORT_W-1:0] mc;
        logic [PORT_W-1:0] md;
        mb = PORT_W'($urandom_range(0, 255));
        mc = PORT_W'($urandom_range(0, 255));
        md = PORT_W'($urandom_range(0, 255));
        case (p)
            0:       begin mb = 8'hFF; mc = 8'hFF; md = 8'hFF; end
            1:       begin mb = 8'h00; mc = 8'h00; md = 8'h00; end
            2:       begin mb = 8'h0F; mc = 8'hF0; md = 8'hA5; end
            3:       begin mb = 8'hFF; mc = 8'hFF; md = 8'hFF; end
            5:       begin mb = 8'h01; mc = 8'h80; md = 8'hFF; end
            7:       begin mb = 8'hFF; mc = 8'h00; md = 8'h55; end
            default: begin end
        endcase
        set_key_mask(REG_MASK_B, mb);
        set_key_mask(REG_MASK_C, mc);
        set_key_mask(REG_MASK_D, md);
    endtask

    // mostly key presses and releases followed by reads, with some noise
    task automatic queue_random_phase(input int count);
        int made;
        int pick;
        int n;
        int port;
        int bit_no;
        made = 0;
        while (made < count)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 55)
            begin
                n = $urandom_range(1, 3);
                for (int j = 0; j < n; j++)
                begin
                    port   = $urandom_range(0, 2);
                    bit_no = $urandom_range(0, PORT_W - 1);
                    raw_pins[port][bit_no] = ~raw_pins[port][bit_no];
                end
                queue_raw(OP_TICK);
                made++;
                n = $urandom_range(0, 4);
                for (int j = 0; j < n; j++)
                begin
                    queue_raw(OP_READ);
                    made++;
                end
            end
            else if (pick < 65)
            begin
                // noisy sample, may overrun the ring
                for (int j = 0; j < 3; j++)
                    raw_pins[j] = PORT_W'($urandom_range(0, 255));
                queue_raw(OP_TICK);
                made++;
            end
            else if (pick < 75)
            begin
                n = $urandom_range(1, 6);
                for (int j = 0; j < n; j++)
                begin
                    queue_raw(OP_READ);
                    made++;
                end
            end
            else if (pick < 82)
            begin
                for (int j = 0; j < 3; j++)
                    raw_pins[j] = PORT_W'($urandom_range(0, 255));
                queue_raw(OP_BASELINE);
                made++;
            end
            else if (pick < 86)
            begin
                // ignored by the block, not counted
                queue_item(OP_UNUSED, PORT_W'($urandom_range(0, 255)),
                           PORT_W'($urandom_range(0, 255)),
                           PORT_W'($urandom_range(0, 255)));
            end
            else
            begin
                queue_raw(OP_TICK);
                made++;
            end
        end
    endtask

    // main sequence
    initial
    begin
        cfg_ch.valid = 1'b0;
        cfg_ch.index = REG_MASK_B;
        cfg_ch.data  = '0;
        for (int i = 0; i < DEPTH; i++)
            ring[i] = '0;
        // let the clocked blocks reach their event controls first
        #0 rst_n = 1'b0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed items with reset masks
        queue_item(OP_READ,     8'hFF, 8'hFF, 8'hFF);
        queue_item(OP_TICK,     8'hFF, 8'hFF, 8'hFF);
        queue_item(OP_READ,     8'h00, 8'h00, 8'h00);
        queue_item(OP_TICK,     8'h00, 8'hFF, 8'hFF);
        queue_item(OP_READ,     8'h00, 8'hFF, 8'hFF);
        queue_item(OP_BASELINE, 8'h00, 8'h00, 8'h00);
        queue_item(OP_UNUSED,   8'hFF, 8'hFF, 8'hFF);
        queue_item(OP_TICK,     8'h80, 8'h01, 8'hFF);
        queue_item(OP_TICK,     8'h00, 8'h00, 8'h00);
        // full sweep while events are pending: the ring overruns
        queue_item(OP_TICK,     8'hFF, 8'hFF, 8'hFF);
        for (int i = 0; i < 6; i++)
            queue_item(OP_READ, 8'h5A, 8'hA5, 8'h3C);
        queue_item(OP_TICK,     8'hAA, 8'h55, 8'h00);
        queue_item(OP_UNUSED,   8'h00, 8'h00, 8'h00);
        queue_item(OP_BASELINE, 8'hFF, 8'hFF, 8'hFF);
        for (int i = 0; i < 4; i++)
            queue_item(OP_READ, 8'hFF, 8'h00, 8'hFF);
        wait_for_idle();

        // random phases, masks changed while idle
        for (int p = 0; p < PHASES; p++)
        begin
            program_masks(p);
            queue_random_phase(PHASE_ITEMS);
            phase_no <= p;
            wait_for_idle();
        end

        if (error_count == 0)
            $display("testbench: done, clean");
        else
            $display("testbench: done, errors");
        $finish;
    end

endmodule
